FILE: design/blpcd_pkg.sv
// ============================================================================
// blpcd_pkg: shared types and constants of the button press classifier
// Holds the button count, the field widths and the beat layouts.
// ============================================================================
`default_nettype none

package blpcd_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int ID_W        = 4;
  localparam int CNT_W       = 6;
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 6'd30;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_LEVEL = 1'b1
  } req_e;

  typedef enum logic {
    EVENT_SINGLE = 1'b0,
    EVENT_COMBO  = 1'b1
  } event_e;

  typedef struct packed {
    req_e            req_type;
    logic [ID_W-1:0] button_id;
    logic            level;
  } item_t;

  typedef struct packed {
    event_e          event_kind;
    logic [ID_W-1:0] released_button;
    logic [ID_W-1:0] partner_button;
    logic            long_press;
  } result_t;

endpackage

`default_nettype wire

FILE: design/blpcd_core.sv
// ============================================================================
// blpcd_core: button state and press classification
// Keeps held flags and hold counters; classifies one item per enabled cycle.
// ============================================================================
`default_nettype none

module blpcd_core
  import blpcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire item_t            item_i,
  input  wire logic [CNT_W-1:0] ticks_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  logic [NUM_BUTTONS-1:0] held_q, held_d;
  logic [CNT_W-1:0]       cnt_q [NUM_BUTTONS];
  logic [CNT_W-1:0]       cnt_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] others;
  logic [BTN_IDX_W-1:0]   sel_idx;
  logic [BTN_IDX_W-1:0]   partner_idx;
  logic                   partner_found;
  logic                   in_range;

  always_comb begin
    sel_idx  = BTN_IDX_W'(item_i.button_id);
    in_range = 32'(item_i.button_id) < NUM_BUTTONS;
    others   = held_q;
    others[sel_idx] = 1'b0;

    partner_found = 1'b0;
    partner_idx   = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (others[i]) begin
        partner_found = 1'b1;
        partner_idx   = BTN_IDX_W'(i);
      end
    end

    held_d      = held_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (en_i) begin
      if (item_i.req_type == REQ_TICK) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - CNT_W'(1);
          end
        end
      end else if (in_range && (held_q[sel_idx] != item_i.level)) begin
        held_d[sel_idx] = item_i.level;
        if (item_i.level) begin
          cnt_d[sel_idx] = ticks_i;
        end else begin
          res_valid_o           = 1'b1;
          res_o.released_button = item_i.button_id;
          res_o.long_press      = (cnt_q[sel_idx] == '0);
          res_o.event_kind      = EVENT_SINGLE;
          if (partner_found) begin
            held_d[partner_idx]  = 1'b0;
            cnt_d[partner_idx]   = '0;
            res_o.event_kind     = EVENT_COMBO;
            res_o.partner_button = ID_W'(partner_idx);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/button_long_press_combo_detector.sv
// ============================================================================
// button_long_press_combo_detector: long-press and chord classifier
// Turns tick and button-level beats into single and combo release events.
// ============================================================================
//
// Channel   Dir  Fields
// s_axis    in   tuser: req_type; tdata: button_id, level
// m_axis    out  tuser: event_kind; tdata: released_button, partner_button,
//                long_press
// cfg       in   long_press_ticks
//
// One beat is accepted per cycle unless the output stalls; a beat passes
// through the input register and then the result register.
// Reset releases all buttons, clears all counters and loads 30 ticks.
// A stalled output holds the result and the input register, and input
// beats keep flowing while the result register is free or being taken.
`default_nettype none

module button_long_press_combo_detector
  import blpcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [7:0]       s_axis_tdata_i,  // [3:0] button_id, [4] level
  input  wire logic             s_axis_tuser_i,  // [0] req_type
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [15:0]           m_axis_tdata_o,  // [3:0] released, [7:4] partner, [8] long
  output logic                  m_axis_tuser_o   // [0] event_kind
);

  logic             in_valid_q;
  item_t            in_item_q;
  logic             out_valid_q;
  result_t          out_res_q;
  logic [CNT_W-1:0] ticks_q;
  logic             advance;
  logic             res_valid;
  result_t          res;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ticks_q     <= LONG_PRESS_RESET;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.req_type  <= req_e'(s_axis_tuser_i);
      in_item_q.button_id <= s_axis_tdata_i[ID_W-1:0];
      in_item_q.level     <= s_axis_tdata_i[ID_W];
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  blpcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (in_item_q),
    .ticks_i     (ticks_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.event_kind;
  assign m_axis_tdata_o  = {7'b0, out_res_q.long_press, out_res_q.partner_button,
                            out_res_q.released_button};

endmodule

`default_nettype wire
